// File: src/ditmono_pkg.sv
package ditmono_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int CFG_W  = 11;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int ERR_W  = 12;
	localparam int SUM_W  = 14;
	localparam int DIV_W  = 18;
	localparam int GRAY_W = 8;
	localparam int ADDR_W = 3;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(128);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(64);

	// register index, taken from paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam int GW_B     = 18;
	localparam int GW_G     = 184;
	localparam int GW_R     = 54;
	localparam int GRAY_RND = 128;
	localparam int THRESH   = 127;
	localparam int WHITE_LV = 255;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	typedef struct packed {
		logic             dot_black;
		logic             mask_white;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             frame_last;
	} mono_t;

	typedef struct packed {
		logic             white;
		logic [ERR_W-1:0] rc_next;
		logic [ERR_W-1:0] pb0_next;
		logic [ERR_W-1:0] pb1_next;
		logic             wa_en;
		logic [ERR_W-1:0] wa_data;
		logic             wb_en;
		logic [ERR_W-1:0] wb_data;
	} diff_t;

	// signed divide by 16, truncating toward zero
	function automatic logic signed [DIV_W-1:0] div16(input logic signed [DIV_W-1:0] x);
		logic signed [DIV_W-1:0] rnd;
		logic signed [DIV_W-1:0] t;
		rnd = DIV_W'(15);
		t = x[DIV_W-1] ? x + rnd : x;
		return t >>> 4;
	endfunction

endpackage

// File: src/ditmono_ram.sv
module ditmono_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/ditmono_diffuse.sv
module ditmono_diffuse import ditmono_pkg::*; (
	input  logic [GRAY_W-1:0] gray,
	input  logic [ERR_W-1:0]  rc,
	input  logic [ERR_W-1:0]  below,
	input  logic [ERR_W-1:0]  pb0,
	input  logic [ERR_W-1:0]  pb1,
	input  logic [COL_W-1:0]  col,
	input  logic              last_col,
	input  logic              last_row,
	output diff_t             d
);

	localparam logic signed [SUM_W-1:0] THR = SUM_W'(THRESH);
	localparam logic signed [SUM_W-1:0] WLV = SUM_W'(WHITE_LV);
	localparam logic signed [DIV_W-1:0] K7  = DIV_W'(7);
	localparam logic signed [DIV_W-1:0] K5  = DIV_W'(5);
	localparam logic signed [DIV_W-1:0] K3  = DIV_W'(3);

	logic signed [SUM_W-1:0] old_v;
	logic signed [SUM_W-1:0] err;
	logic signed [DIV_W-1:0] err_x;
	logic signed [DIV_W-1:0] e7, e5, e3, e1;
	logic                    white;
	logic [ERR_W-1:0]        mid;

	always_comb begin
		old_v = $signed({{(SUM_W-GRAY_W){1'b0}}, gray})
			+ SUM_W'($signed(rc)) + SUM_W'($signed(below));
		white = old_v > THR;
		err   = white ? old_v - WLV : old_v;
		err_x = DIV_W'(err);
		e7    = div16(err_x * K7);
		e5    = div16(err_x * K5);
		e3    = div16(err_x * K3);
		e1    = div16(err_x);
		mid   = pb1 + e5[ERR_W-1:0];

		d.white     = white;
		d.rc_next   = last_col ? '0 : e7[ERR_W-1:0];
		d.wa_en     = !last_row && (col != '0);
		d.wa_data   = pb0 + e3[ERR_W-1:0];
		d.wb_en     = !last_row && last_col;
		d.wb_data   = mid;
		// row end or last row: no next-row partial sum carries into the next column
		d.pb0_next  = (last_row || last_col) ? '0 : mid;
		d.pb1_next  = (last_row || last_col) ? '0 : e1[ERR_W-1:0];
	end

endmodule

// File: src/rgb_to_dithered_mono.sv
// A pixel's result is registered in the stage 1 registers, then in the output register.
// Throughput: one pixel per clock while the receiver takes results; the bound is the
// loop that carries the right-hand error share from one pixel into the next.
// Next-row errors live in a one-port-write, one-port-read RAM with forwarding.
// Reset: 128 x 64 image, position zero, then a sweep over all MAX_WIDTH (1024) entries
// zeroes the row error RAM with pixel_ready low; config writes still taken.
module rgb_to_dithered_mono import ditmono_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_ready,
	input  pix_t              pixel,
	output logic              mono_valid,
	input  logic              mono_ready,
	output mono_t             mono,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [CFG_W-1:0] width_q, height_q;
	logic [CFG_W-1:0] w_eff, h_eff;
	logic [COL_W-1:0] col_last;
	logic [ROW_W-1:0] row_last;
	logic             reg_idx;

	logic [COL_W:0]   clr_q;
	logic             clearing;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             acc, last_col0, last_row0;
	logic [15:0]      gray_sum;

	logic              valid_s1;
	logic [GRAY_W-1:0] gray_s1;
	logic [COL_W-1:0]  col_s1;
	logic [ROW_W-1:0]  row_s1;
	logic              last_col_s1, last_row_s1;
	logic              fwd_s1;
	logic [ERR_W-1:0]  fwd_data_s1;
	logic              commit;

	logic [ERR_W-1:0] rc_q, pb0_q, pb1_q;
	logic [ERR_W-1:0] below;
	diff_t            d;

	logic             defer_q;
	logic [COL_W-1:0] defer_addr_q;
	logic [ERR_W-1:0] defer_data_q;

	logic             mem_we;
	logic [COL_W-1:0] mem_waddr;
	logic [ERR_W-1:0] mem_wdata;
	logic [ERR_W-1:0] mem_rdata;
	logic             fwd_hit;

	logic  mono_valid_q;
	mono_t mono_q;

	// configuration
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
		endcase
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = CFG_W'(1);
		end else if (width_q > CFG_W'(MAX_WIDTH)) begin
			w_eff = CFG_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = CFG_W'(1);
		end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign col_last = COL_W'(w_eff - CFG_W'(1));
	assign row_last = ROW_W'(h_eff - CFG_W'(1));

	// zero the row store after reset
	assign clearing = (clr_q < (COL_W + 1)'(MAX_WIDTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// stage 0: position, gray level, RAM read
	assign commit      = valid_s1 && (!mono_valid_q || mono_ready);
	assign pixel_ready = !clearing && (!valid_s1 || commit);
	assign acc         = pixel_valid && pixel_ready;
	assign last_col0   = (col_q >= col_last);
	assign last_row0   = (row_q >= row_last);
	assign gray_sum    = 16'(GW_B) * 16'(pixel.blue) + 16'(GW_G) * 16'(pixel.green)
		+ 16'(GW_R) * 16'(pixel.red) + 16'(GRAY_RND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (last_col0) begin
				col_q <= '0;
				row_q <= last_row0 ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// a write landing on the address read in the same cycle is forwarded
	assign fwd_hit = mem_we && (mem_waddr == col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			gray_s1     <= gray_sum[15:8];
			col_s1      <= col_q;
			row_s1      <= row_q;
			last_col_s1 <= last_col0;
			last_row_s1 <= last_row0;
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= mem_wdata;
		end
	end

	// stage 1: error diffusion
	always_comb begin
		if (row_s1 == '0) begin
			below = '0;
		end else if (fwd_s1) begin
			below = fwd_data_s1;
		end else begin
			below = mem_rdata;
		end
	end

	ditmono_diffuse u_diffuse (
		.gray     (gray_s1),
		.rc       (rc_q),
		.below    (below),
		.pb0      (pb0_q),
		.pb1      (pb1_q),
		.col      (col_s1),
		.last_col (last_col_s1),
		.last_row (last_row_s1),
		.d        (d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q  <= '0;
			pb0_q <= '0;
			pb1_q <= '0;
		end else if (commit) begin
			rc_q  <= d.rc_next;
			pb0_q <= d.pb0_next;
			pb1_q <= d.pb1_next;
		end
	end

	// a row-end pixel that makes two writes holds the second in the defer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			defer_q <= 1'b0;
		end else if (commit && d.wa_en && d.wb_en) begin
			defer_q <= 1'b1;
		end else begin
			defer_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && d.wa_en && d.wb_en) begin
			defer_addr_q <= col_s1;
			defer_data_q <= d.wb_data;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = col_s1;
		mem_wdata = d.wb_data;
		if (clearing) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q[COL_W-1:0];
			mem_wdata = '0;
		end else if (commit && d.wa_en) begin
			mem_we    = 1'b1;
			mem_waddr = col_s1 - 1'b1;
			mem_wdata = d.wa_data;
		end else if (commit && d.wb_en) begin
			mem_we    = 1'b1;
		end else if (defer_q) begin
			mem_we    = 1'b1;
			mem_waddr = defer_addr_q;
			mem_wdata = defer_data_q;
		end
	end

	ditmono_ram #(
		.WIDTH (ERR_W),
		.DEPTH (MAX_WIDTH)
	) u_row_err (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (acc),
		.raddr (col_q),
		.rdata (mem_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_valid_q <= 1'b0;
		end else if (commit) begin
			mono_valid_q <= 1'b1;
		end else if (mono_ready) begin
			mono_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			mono_q.dot_black  <= !d.white;
			mono_q.mask_white <= (gray_s1 == GRAY_W'(WHITE_LV));
			mono_q.column     <= col_s1;
			mono_q.row        <= row_s1;
			mono_q.frame_last <= last_col_s1 && last_row_s1;
		end
	end

	assign mono_valid = mono_valid_q;
	assign mono       = mono_q;

`ifndef ASSERT_OFF
	a_defer_port_free: assert property (@(posedge clk) disable iff (!arst_n)
		defer_q |-> !(commit && (d.wa_en || d.wb_en)))
		else $error("deferred row store write collides with a commit write");

	a_no_take_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pixel_ready)
		else $error("pixel taken during row store sweep");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_col0 && last_row0) |=> (col_q == '0 && row_q == '0))
		else $error("position did not wrap at frame end");

	a_row_end_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && last_col_s1) |=> (pb0_q == '0 && pb1_q == '0 && rc_q == '0))
		else $error("error carry survived a row end");
`endif

endmodule

// File: bench/rgb_to_dithered_mono_tb.sv
module rgb_to_dithered_mono_tb;
	import ditmono_pkg::*;

	localparam logic [ADDR_W-1:0] WIDTH_ADDR  = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] HEIGHT_ADDR = ADDR_W'(4);
	localparam int MAX_PRINTED = 40;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              pixel_valid = 1'b0;
	logic              pixel_ready;
	pix_t              pixel = '0;
	logic              mono_valid;
	logic              mono_ready = 1'b0;
	mono_t             mono;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	// shadow of the block: size registers, error store and raster position
	logic [CFG_W-1:0]        width_cfg = CFG_W'(128);
	logic [CFG_W-1:0]        height_cfg = CFG_W'(64);
	logic signed [ERR_W-1:0] row_err [MAX_WIDTH];
	logic signed [ERR_W-1:0] below_acc [2];
	logic signed [ERR_W-1:0] carry_right = '0;
	int                      pos_col = 0;
	int                      pos_row = 0;

	pix_t  pix_backlog [$];
	mono_t mono_due [$];

	int sender_gap_pct = 14;
	int sink_gap_pct = 14;
	logic hold_sink = 1'b0;
	logic sink_stall = 1'b0;

	int mismatches = 0;
	int pixels_checked = 0;
	int frames_done = 0;
	int white_masks = 0;
	int size_settings = 0;
	int corner_next = 0;

	logic [23:0] corner_rgb [12] = '{
		24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h808080,
		24'h7F7F7F, 24'hFFFFFE, 24'hFEFEFE, 24'h010101, 24'h55AA55, 24'hAA55AA
	};

	rgb_to_dithered_mono i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// one pixel through the dithering arithmetic; advances the shadow state
	function automatic mono_t dither_pixel(input pix_t px);
		int w, h, gray, below, level, err, e3, e5, e1;
		bit last_col, last_row, white;
		mono_t m;
		w = (width_cfg == 0) ? 1 : (width_cfg > MAX_WIDTH) ? MAX_WIDTH : int'(width_cfg);
		h = (height_cfg == 0) ? 1 : (height_cfg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_cfg);
		last_col = (pos_col + 1 >= w);
		last_row = (pos_row + 1 >= h);
		gray = (18 * px.blue + 184 * px.green + 54 * px.red + 128) >> 8;
		// row zero sees a cleared store
		below = (pos_row != 0) ? int'(row_err[pos_col]) : 0;
		level = gray + int'(carry_right) + below;
		white = (level > 127);
		err = level - (white ? 255 : 0);
		carry_right = last_col ? '0 : ERR_W'(err * 7 / 16);
		if (!last_row) begin
			e3 = err * 3 / 16;
			e5 = err * 5 / 16;
			e1 = err / 16;
			if (pos_col > 0)
				row_err[pos_col - 1] = ERR_W'(int'(below_acc[0]) + e3);
			if (last_col) begin
				row_err[pos_col] = ERR_W'(int'(below_acc[1]) + e5);
				below_acc[0] = '0;
				below_acc[1] = '0;
			end else begin
				below_acc[0] = ERR_W'(int'(below_acc[1]) + e5);
				below_acc[1] = ERR_W'(e1);
			end
		end else begin
			below_acc[0] = '0;
			below_acc[1] = '0;
		end
		m.dot_black  = !white;
		m.mask_white = (gray == 255);
		m.column     = COL_W'(pos_col);
		m.row        = ROW_W'(pos_row);
		m.frame_last = last_col && last_row;
		if (last_col) begin
			pos_col = 0;
			pos_row = last_row ? 0 : pos_row + 1;
		end else begin
			pos_col = pos_col + 1;
		end
		return m;
	endfunction

	function automatic pix_t random_pixel();
		int pick;
		logic [7:0] level;
		pix_t px;
		pick = $urandom_range(99);
		level = 8'($urandom_range(118, 137));
		px = 24'($urandom());
		if (pick < 15) begin
			// gray levels around the threshold
			px = {level, level, level};
		end else if (pick < 25) begin
			px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
			px.green = $urandom_range(1) ? 8'hFF : 8'h00;
			px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
		end else if (pick < 35) begin
			px.blue  = 8'($urandom_range(240, 255));
			px.green = 8'($urandom_range(240, 255));
			px.red   = 8'($urandom_range(240, 255));
		end
		return px;
	endfunction

	// sender
	always @(posedge clk) begin
		if (pixel_valid && pixel_ready)
			mono_due.push_back(dither_pixel(pixel));
		if (!pixel_valid || pixel_ready) begin
			if (pix_backlog.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
				pixel_valid <= 1'b1;
				pixel <= pix_backlog.pop_front();
			end else begin
				pixel_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk)
		mono_ready <= !sink_stall && ($urandom_range(99) >= sink_gap_pct);

	// long receiver hold-off, once
	initial begin
		wait (hold_sink);
		@(posedge clk);
		sink_stall <= 1'b1;
		repeat (300) @(posedge clk);
		sink_stall <= 1'b0;
	end

	always @(posedge clk) begin : watch_mono
		mono_t want;
		if (mono_valid && mono_ready) begin
			if (mono_due.size() == 0) begin
				report_mismatch($sformatf("result row %0d col %0d with none expected",
					mono.row, mono.column));
			end else begin
				want = mono_due.pop_front();
				if (mono.dot_black !== want.dot_black)
					report_mismatch($sformatf("dot_black %b want %b (row %0d col %0d)",
						mono.dot_black, want.dot_black, want.row, want.column));
				if (mono.mask_white !== want.mask_white)
					report_mismatch($sformatf("mask_white %b want %b (row %0d col %0d)",
						mono.mask_white, want.mask_white, want.row, want.column));
				if (mono.column !== want.column)
					report_mismatch($sformatf("column %0d want %0d (row %0d)",
						mono.column, want.column, want.row));
				if (mono.row !== want.row)
					report_mismatch($sformatf("row %0d want %0d (col %0d)",
						mono.row, want.row, want.column));
				if (mono.frame_last !== want.frame_last)
					report_mismatch($sformatf("frame_last %b want %b (row %0d col %0d)",
						mono.frame_last, want.frame_last, want.row, want.column));
				pixels_checked++;
				frames_done += want.frame_last;
				white_masks += want.mask_white;
			end
		end
	end

	task automatic wait_drained;
		do
			@(negedge clk);
		while (pix_backlog.size() != 0 || pixel_valid || mono_due.size() != 0);
	endtask

	task automatic check_size_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(want))
			report_mismatch($sformatf("register at %0d reads %0h want %0h", addr, prdata, want));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_size_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
		logic [31:0] word;
		word = $urandom();
		word[CFG_W-1:0] = val;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == WIDTH_ADDR)
			width_cfg = val;
		else
			height_cfg = val;
		check_size_reg(addr, val);
	endtask

	task automatic set_image_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		wait_drained;
		write_size_reg(WIDTH_ADDR, w);
		write_size_reg(HEIGHT_ADDR, h);
		size_settings++;
		@(negedge clk);
	endtask

	task automatic feed_corners(input int n);
		for (int i = 0; i < n; i++) begin
			pix_backlog.push_back(corner_rgb[corner_next]);
			corner_next = (corner_next + 1) % 12;
		end
	endtask

	// random pixels; now and then pause until every result is back
	task automatic feed_pixels(input int n);
		int split;
		split = ($urandom_range(3) == 0) ? $urandom_range(1, n - 1) : n;
		for (int i = 0; i < n; i++) begin
			if (i == split)
				wait_drained;
			pix_backlog.push_back(random_pixel());
		end
	endtask

	initial begin
		logic [CFG_W-1:0] w_pick, h_pick;
		int pick, batch, phase, random_items;
		for (int i = 0; i < MAX_WIDTH; i++)
			row_err[i] = '0;
		below_acc[0] = '0;
		below_acc[1] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		check_size_reg(WIDTH_ADDR, CFG_W'(128));
		check_size_reg(HEIGHT_ADDR, CFG_W'(64));

		// small frame with color extremes, then one column, one row, full size
		set_image_size(CFG_W'(4), CFG_W'(3));
		feed_corners(12);
		set_image_size(CFG_W'(0), CFG_W'(2047));
		feed_corners(2);
		set_image_size(CFG_W'(3), CFG_W'(1));
		feed_corners(3);
		set_image_size(CFG_W'(1024), CFG_W'(1024));
		feed_corners(4);
		// shrink mid-frame: the current column becomes the last one
		set_image_size(CFG_W'(2), CFG_W'(2));
		feed_corners(3);

		phase = 0;
		random_items = 0;
		while (random_items < 450) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				w_pick = (pick < 3) ? CFG_W'(1024) : (pick < 6) ? CFG_W'(2047) :
					CFG_W'($urandom_range(600, 1100));
				h_pick = CFG_W'($urandom_range(1, 3));
			end else if (pick < 18) begin
				w_pick = CFG_W'($urandom_range(0, 3));
				h_pick = (pick < 13) ? CFG_W'(1024) : (pick < 15) ? CFG_W'(0) :
					CFG_W'($urandom_range(1024, 2047));
			end else begin
				w_pick = CFG_W'($urandom_range(1, 16));
				h_pick = CFG_W'($urandom_range(1, 6));
			end
			set_image_size(w_pick, h_pick);
			sender_gap_pct = 14;
			sink_gap_pct = 14;
			batch = $urandom_range(15, 50);
			if (phase == 2) begin
				sender_gap_pct = 0;
				sink_gap_pct = 0;
				batch = 90;
			end else if (phase == 4) begin
				// keep offering while the receiver holds off
				sender_gap_pct = 0;
				hold_sink = 1'b1;
				batch = 70;
			end
			feed_pixels(batch);
			random_items += batch;
			phase++;
		end

		wait_drained;
		repeat (20) @(posedge clk);
		$display("Checked %0d dithered pixels over %0d image sizes (incl. clamped and mid-frame)",
			pixels_checked, size_settings);
		$display("Saw %0d frame ends and %0d pure-white pixels", frames_done, white_masks);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#1000000;
		$display("Timeout with %0d results outstanding", mono_due.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: rgb_to_dithered_mono.f
src/ditmono_pkg.sv
src/ditmono_ram.sv
src/ditmono_diffuse.sv
src/rgb_to_dithered_mono.sv
bench/rgb_to_dithered_mono_tb.sv
